### design/gcb_pkg.sv
// Shared types, constants and helpers for the grid cell binning block.
`default_nettype none
package gcb_pkg;

    localparam int COORD_W   = 24;
    localparam int WIDTH_W   = 23;
    localparam int CNT_W     = 4;
    localparam int AXIS_W    = 3;
    localparam int CELL_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [CNT_W-1:0] GRID_COLS = 4'd8;
    localparam logic [CNT_W-1:0] GRID_ROWS = 4'd8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z  = 3'd5;

    localparam logic [COORD_W-1:0] RST_ORIGIN = 24'd0;
    localparam logic [WIDTH_W-1:0] RST_WIDTH  = 23'd5120;
    localparam logic [CNT_W-1:0]   RST_CELLS  = 4'd8;

    localparam logic FP_BOX     = 1'b0;
    localparam logic FP_SEGMENT = 1'b1;

    typedef struct packed {
        logic                      footprint_kind;
        logic                      enabled;
        logic signed [COORD_W-1:0] point_a_x;
        logic signed [COORD_W-1:0] point_a_z;
        logic signed [COORD_W-1:0] point_b_x;
        logic signed [COORD_W-1:0] point_b_z;
    } t_item;

    typedef struct packed {
        logic [CELL_W-1:0] cell_index;
        logic              last_cell;
    } t_result;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_z;
        logic [WIDTH_W-1:0]        width_x;
        logic [WIDTH_W-1:0]        width_z;
        logic [CNT_W-1:0]          ncol;
        logic [CNT_W-1:0]          nrow;
    } t_cfg;

    typedef struct packed {
        logic [AXIS_W-1:0] x0;
        logic [AXIS_W-1:0] x1;
        logic [AXIS_W-1:0] z0;
        logic [AXIS_W-1:0] z1;
    } t_span;

    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c,
                                                   input logic [CNT_W-1:0] lim);
        logic [CNT_W-1:0] r;
        r = c;
        if (r == '0) begin
            r = 4'd1;
        end
        if (r > lim) begin
            r = lim;
        end
        return r;
    endfunction

    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
        return (w == '0) ? WIDTH_W'(1) : w;
    endfunction

endpackage
`default_nettype wire

### design/gcb_front.sv
// Front end: accepts a footprint, orders the bounds of a segment and bins each bound by shared division.
`default_nettype none
module gcb_front import gcb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_accept,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output logic       o_busy,
    output logic       o_push,
    output t_span      o_span
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    localparam logic [2:0] STEP_LOAD  = 3'd0;
    localparam logic [2:0] STEP_SAT   = 3'd1;
    localparam logic [2:0] STEP_CLAMP = 3'd5;

    logic [1:0]                r_state;
    logic [1:0]                r_opnd;
    logic [2:0]                r_step;
    logic signed [COORD_W-1:0] r_pos [4];
    logic [COORD_W-1:0]        r_rem;
    logic                      r_neg;
    logic [3:0]                r_q;
    logic [AXIS_W-1:0]         r_idx [4];

    logic                      x_axis;
    logic signed [COORD_W-1:0] origin;
    logic [WIDTH_W-1:0]        width;
    logic [CNT_W-1:0]          cnt;
    logic signed [COORD_W:0]   diff;
    logic [2:0]                sh_full;
    logic [1:0]                sh;
    logic [COORD_W+2:0]        rem_ext;
    logic [COORD_W+2:0]        wsh;
    logic                      ge;
    logic [AXIS_W-1:0]         clamped;
    logic signed [COORD_W-1:0] ax, az, bx, bz;

    assign x_axis  = !r_opnd[1];
    assign origin  = x_axis ? i_cfg.origin_x : i_cfg.origin_z;
    assign width   = x_axis ? i_cfg.width_x  : i_cfg.width_z;
    assign cnt     = x_axis ? i_cfg.ncol     : i_cfg.nrow;
    assign diff    = {r_pos[r_opnd][COORD_W-1], r_pos[r_opnd]} - {origin[COORD_W-1], origin};
    assign sh_full = 3'd4 - r_step;
    assign sh      = sh_full[1:0];
    assign rem_ext = {3'b000, r_rem};
    assign wsh     = {4'b0000, width} << sh;
    assign ge      = rem_ext >= wsh;

    always_comb begin
        if (r_neg) begin
            clamped = '0;
        end else if (r_q >= cnt) begin
            clamped = AXIS_W'(cnt - 4'd1);
        end else begin
            clamped = r_q[AXIS_W-1:0];
        end
    end

    assign ax = i_item.point_a_x;
    assign az = i_item.point_a_z;
    assign bx = i_item.point_b_x;
    assign bz = i_item.point_b_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_opnd  <= '0;
            r_step  <= STEP_LOAD;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept && i_item.enabled) begin
                        if (i_item.footprint_kind == FP_SEGMENT) begin
                            r_pos[0] <= (ax < bx) ? ax : bx;
                            r_pos[1] <= (ax > bx) ? ax : bx;
                            r_pos[2] <= (az < bz) ? az : bz;
                            r_pos[3] <= (az > bz) ? az : bz;
                        end else begin
                            r_pos[0] <= ax;
                            r_pos[1] <= bx;
                            r_pos[2] <= az;
                            r_pos[3] <= bz;
                        end
                        r_opnd  <= '0;
                        r_step  <= STEP_LOAD;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    case (r_step)
                        STEP_LOAD: begin
                            r_rem <= diff[COORD_W-1:0];
                            r_neg <= diff[COORD_W];
                            r_q   <= '0;
                        end
                        STEP_SAT: begin
                            if (ge) begin
                                r_q <= 4'd8;
                            end
                        end
                        STEP_CLAMP: begin
                            r_idx[r_opnd] <= clamped;
                        end
                        default: begin
                            if (ge && !r_q[3]) begin
                                r_rem <= r_rem - wsh[COORD_W-1:0];
                                r_q   <= r_q | (4'd1 << sh);
                            end
                        end
                    endcase
                    if (r_step == STEP_CLAMP) begin
                        r_step <= STEP_LOAD;
                        if (r_opnd == 2'd3) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_opnd <= r_opnd + 2'd1;
                        end
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_PUSH: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_span  = '{x0: r_idx[0], x1: r_idx[1], z0: r_idx[2], z1: r_idx[3]};
    assign o_push  = (r_state == S_PUSH) && (r_idx[0] <= r_idx[1]) && (r_idx[2] <= r_idx[3]);

endmodule
`default_nettype wire

### design/gcb_queue.sv
// Short queue of cell ranges between front and back end.
`default_nettype none
module gcb_queue import gcb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_span i_span,
    input  wire logic  i_pop,
    output logic       o_valid,
    output logic       o_full,
    output t_span      o_span
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_span              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_QW-1:0]  r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_QW'(QUEUE_DEPTH));
    assign o_span  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_QW'(1);
                2'b01:   r_cnt <= r_cnt - CNT_QW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

### design/gcb_back.sv
// Back end: walks a cell range row by row and issues one cell word per cycle.
`default_nettype none
module gcb_back import gcb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_span            i_span,
    input  wire logic [CNT_W-1:0] i_ncol,
    output logic                  o_pop,
    output logic                  o_strobe,
    output t_result               o_result
);

    logic              r_act;
    logic [AXIS_W-1:0] r_x;
    logic [AXIS_W-1:0] r_x0;
    logic [AXIS_W-1:0] r_x1;
    logic [AXIS_W-1:0] r_z;
    logic [AXIS_W-1:0] r_z1;
    logic [CELL_W-1:0] r_base;
    logic              r_strobe;
    t_result           r_res;

    logic [CELL_W:0]   base_prod;
    logic              row_end;
    logic              is_last;

    assign base_prod = (CELL_W + 1)'(i_span.z0) * (CELL_W + 1)'(i_ncol);
    assign row_end   = (r_x == r_x1);
    assign is_last   = row_end && (r_z == r_z1);
    assign o_pop     = !r_act && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_act;
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (r_act && is_last) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x    <= i_span.x0;
            r_x0   <= i_span.x0;
            r_x1   <= i_span.x1;
            r_z    <= i_span.z0;
            r_z1   <= i_span.z1;
            r_base <= base_prod[CELL_W-1:0];
        end else if (r_act) begin
            if (row_end) begin
                r_x    <= r_x0;
                r_z    <= r_z + AXIS_W'(1);
                r_base <= r_base + CELL_W'(i_ncol);
            end else begin
                r_x <= r_x + AXIS_W'(1);
            end
        end
        if (r_act) begin
            r_res.cell_index <= r_base + CELL_W'(r_x);
            r_res.last_cell  <= is_last;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule
`default_nettype wire

### design/grid_cell_binning_of_bounds.sv
// Top level of the grid cell binning block: configuration registers and the two ends.
//
// Input: an item (a box or segment footprint on the x/z plane) is taken at a clock
// edge where start is high and busy is low. Configuration registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_wdata at any edge where i_cfg_we is high.
// Output: each covered cell is presented for one cycle with o_strobe high,
// rows outer and columns inner; last_cell marks the final cell of an item.
// Disabled items and empty ranges produce no words.
// Timing: the front end bins the four bounds one after another through a shared
// restoring divider (load, saturation test, subtract steps, clamp); busy stays high
// while an enabled item is binned (a disabled item leaves busy low). The back end
// issues one word per cycle, with strobe low between items. The front end works
// on the next item while the back end still walks the previous range, with a
// two-entry queue between. busy also stays high while that queue is full.
// Reset: synchronous, active low; loads default configuration and empties the
// queue. The receiver has no stall; words are never held back.
`default_nettype none
module grid_cell_binning_of_bounds import gcb_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_item                i_item,
    output logic                      o_strobe,
    output t_result                   o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata
);

    logic signed [COORD_W-1:0] r_origin_x;
    logic signed [COORD_W-1:0] r_origin_z;
    logic [WIDTH_W-1:0]        r_width_x;
    logic [WIDTH_W-1:0]        r_width_z;
    logic [CNT_W-1:0]          r_cells_x;
    logic [CNT_W-1:0]          r_cells_z;

    t_cfg    cfg;
    logic    accept;
    logic    front_busy;
    logic    push;
    t_span   push_span;
    logic    q_valid;
    logic    q_full;
    t_span   q_span;
    logic    pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= RST_ORIGIN;
            r_origin_z <= RST_ORIGIN;
            r_width_x  <= RST_WIDTH;
            r_width_z  <= RST_WIDTH;
            r_cells_x  <= RST_CELLS;
            r_cells_z  <= RST_CELLS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X: r_origin_x <= i_cfg_wdata;
                CFG_ORIGIN_Z: r_origin_z <= i_cfg_wdata;
                CFG_WIDTH_X:  r_width_x  <= i_cfg_wdata[WIDTH_W-1:0];
                CFG_WIDTH_Z:  r_width_z  <= i_cfg_wdata[WIDTH_W-1:0];
                CFG_CELLS_X:  r_cells_x  <= i_cfg_wdata[CNT_W-1:0];
                CFG_CELLS_Z:  r_cells_z  <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.origin_x = r_origin_x;
    assign cfg.origin_z = r_origin_z;
    assign cfg.width_x  = eff_width(r_width_x);
    assign cfg.width_z  = eff_width(r_width_z);
    assign cfg.ncol     = sat_count(r_cells_x, GRID_COLS);
    assign cfg.nrow     = sat_count(r_cells_z, GRID_ROWS);

    assign busy   = front_busy || q_full;
    assign accept = start && !busy;

    gcb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_item),
        .i_cfg   (cfg),
        .o_busy  (front_busy),
        .o_push  (push),
        .o_span  (push_span)
    );

    gcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_span  (push_span),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_span  (q_span)
    );

    gcb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_span  (q_span),
        .i_ncol  (cfg.ncol),
        .o_pop   (pop),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

endmodule
`default_nettype wire

### design/gcb_checker.sv
// Port-level checks on the grid cell binning block, bound to its top level.
`default_nettype none
module gcb_checker import gcb_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_busy,
    input wire logic    i_strobe,
    input wire t_result i_result
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_busy && !i_strobe))
        else $error("busy or strobe after reset");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strobe && i_result.last_cell) |=> !i_strobe)
        else $error("word directly after last cell");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strobe && !i_result.last_cell) |=> i_strobe)
        else $error("cell run broken before last cell");

    a_index_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_strobe && !i_result.last_cell) |=>
            (i_result.cell_index > $past(i_result.cell_index)))
        else $error("cell index not rising within an item");

endmodule

bind grid_cell_binning_of_bounds gcb_checker u_gcb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_busy  (busy),
    .i_strobe(o_strobe),
    .i_result(o_result)
);
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the grid cell binner: predicts and checks covered cells.
`timescale 1ns / 100ps
module testbench;
    import gcb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 64;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_item                i_item;
    logic                 o_strobe;
    t_result              o_result;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;

    // shadow copy of the grid registers
    logic signed [COORD_W-1:0] grid_org_x;
    logic signed [COORD_W-1:0] grid_org_z;
    logic [WIDTH_W-1:0]        grid_wid_x;
    logic [WIDTH_W-1:0]        grid_wid_z;
    logic [CNT_W-1:0]          grid_cols;
    logic [CNT_W-1:0]          grid_rows;

    t_result cells_due[$];
    int      errors;
    bit      gaps_on;

    grid_cell_binning_of_bounds dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint usable_count(input logic [CNT_W-1:0] c, input longint lim);
        longint n;
        n = longint'(c);
        if (n < 1) begin
            n = 1;
        end
        if (n > lim) begin
            n = lim;
        end
        return n;
    endfunction

    function automatic longint usable_width(input logic [WIDTH_W-1:0] w);
        return (w == '0) ? 1 : longint'(w);
    endfunction

    function automatic longint bin_index(input longint pos, input logic signed [COORD_W-1:0] org,
                                         input logic [WIDTH_W-1:0] w, input longint n);
        longint q;
        q = (pos - longint'(org)) / usable_width(w);
        if (q < 0) begin
            q = 0;
        end
        if (q >= n) begin
            q = n - 1;
        end
        return q;
    endfunction

    function automatic void predict_cells(input t_item it);
        longint ax, az, bx, bz, lox, hix, loz, hiz;
        longint ncol, nrow, x0, x1, z0, z1;
        t_result r;
        if (!it.enabled) begin
            return;
        end
        ax = longint'($signed(it.point_a_x));
        az = longint'($signed(it.point_a_z));
        bx = longint'($signed(it.point_b_x));
        bz = longint'($signed(it.point_b_z));
        if (it.footprint_kind == FP_SEGMENT) begin
            lox = (ax < bx) ? ax : bx;
            hix = (ax > bx) ? ax : bx;
            loz = (az < bz) ? az : bz;
            hiz = (az > bz) ? az : bz;
        end else begin
            lox = ax;
            hix = bx;
            loz = az;
            hiz = bz;
        end
        ncol = usable_count(grid_cols, longint'(GRID_COLS));
        nrow = usable_count(grid_rows, longint'(GRID_ROWS));
        x0 = bin_index(lox, grid_org_x, grid_wid_x, ncol);
        x1 = bin_index(hix, grid_org_x, grid_wid_x, ncol);
        z0 = bin_index(loz, grid_org_z, grid_wid_z, nrow);
        z1 = bin_index(hiz, grid_org_z, grid_wid_z, nrow);
        if (x0 > x1 || z0 > z1) begin
            return;
        end
        for (longint z = z0; z <= z1; z++) begin
            for (longint x = x0; x <= x1; x++) begin
                r.cell_index = CELL_W'(z * ncol + x);
                r.last_cell  = (z == z1 && x == x1);
                cells_due.insert(cells_due.size(), r);
            end
        end
    endfunction

    function automatic t_item footprint(input logic kind, input logic en,
                                        input longint ax, input longint az,
                                        input longint bx, input longint bz);
        t_item it;
        it.footprint_kind = kind;
        it.enabled        = en;
        it.point_a_x      = COORD_W'(ax);
        it.point_a_z      = COORD_W'(az);
        it.point_b_x      = COORD_W'(bx);
        it.point_b_z      = COORD_W'(bz);
        return it;
    endfunction

    function automatic longint near_grid(input logic signed [COORD_W-1:0] org,
                                         input logic [WIDTH_W-1:0] w, input longint n);
        longint cw, span;
        cw   = usable_width(w);
        span = (n + 4) * cw;
        return longint'(org) + longint'($urandom_range(0, 32'(span))) - 2 * cw;
    endfunction

    function automatic t_item random_footprint();
        t_item it;
        logic signed [COORD_W-1:0] t;
        longint ncol, nrow;
        if ($urandom_range(0, 4) == 0) begin
            it = footprint(1'($urandom), 1'($urandom), longint'($urandom), longint'($urandom),
                           longint'($urandom), longint'($urandom));
            return it;
        end
        ncol = usable_count(grid_cols, longint'(GRID_COLS));
        nrow = usable_count(grid_rows, longint'(GRID_ROWS));
        it = footprint(1'($urandom), $urandom_range(0, 9) != 0,
                       near_grid(grid_org_x, grid_wid_x, ncol),
                       near_grid(grid_org_z, grid_wid_z, nrow),
                       near_grid(grid_org_x, grid_wid_x, ncol),
                       near_grid(grid_org_z, grid_wid_z, nrow));
        if (it.footprint_kind == FP_BOX && $urandom_range(0, 3) != 0) begin
            if ($signed(it.point_a_x) > $signed(it.point_b_x)) begin
                t = it.point_a_x;
                it.point_a_x = it.point_b_x;
                it.point_b_x = t;
            end
            if ($signed(it.point_a_z) > $signed(it.point_b_z)) begin
                t = it.point_a_z;
                it.point_a_z = it.point_b_z;
                it.point_b_z = t;
            end
        end
        return it;
    endfunction

    task automatic hold_off(input int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_footprint(input t_item it);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            hold_off($urandom_range(1, 11));
        end
        @(negedge i_clk);
        i_item = it;
        start  = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_cells(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (cells_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        case (idx)
            CFG_ORIGIN_X: grid_org_x = data;
            CFG_ORIGIN_Z: grid_org_z = data;
            CFG_WIDTH_X:  grid_wid_x = data[WIDTH_W-1:0];
            CFG_WIDTH_Z:  grid_wid_z = data[WIDTH_W-1:0];
            CFG_CELLS_X:  grid_cols  = data[CNT_W-1:0];
            CFG_CELLS_Z:  grid_rows  = data[CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_grid();
        logic [CFG_DAT_W-1:0] d;
        for (int k = 0; k < 2; k++) begin
            d = ($urandom_range(0, 4) == 0) ? CFG_DAT_W'($urandom)
                                            : CFG_DAT_W'($urandom_range(0, 200000) - 100000);
            write_reg(k == 0 ? CFG_ORIGIN_X : CFG_ORIGIN_Z, d);
            case ($urandom_range(0, 9))
                0: d = CFG_DAT_W'($urandom_range(0, 3));
                1: d = CFG_DAT_W'($urandom);
                default: d = {$urandom_range(0, 1) == 0, 23'($urandom_range(256, 30000))};
            endcase
            write_reg(k == 0 ? CFG_WIDTH_X : CFG_WIDTH_Z, d);
            d = CFG_DAT_W'($urandom);
            d[CNT_W-1:0] = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 15))
                                                       : CNT_W'($urandom_range(1, 8));
            write_reg(k == 0 ? CFG_CELLS_X : CFG_CELLS_Z, d);
        end
    endtask

    // reset grid: 8 x 8 cells of 20.0
    task automatic test_reset_grid();
        send_footprint(footprint(FP_BOX, 1'b1, 0, 0, 0, 0));
        send_footprint(footprint(FP_BOX, 1'b1, 0, 0, 40959, 40959));
        send_footprint(footprint(FP_BOX, 1'b1, -8388608, -8388608, 8388607, 8388607));
        send_footprint(footprint(FP_SEGMENT, 1'b1, 30000, 20000, 1000, 100));
        send_footprint(footprint(FP_SEGMENT, 1'b1, 6000, -300, 6000, -300));
        send_footprint(footprint(FP_BOX, 1'b0, 0, 0, 40959, 40959));
        send_footprint(footprint(FP_SEGMENT, 1'b0, 40959, 0, 0, 40959));
        send_footprint(footprint(FP_BOX, 1'b1, 30000, 0, 1000, 0));
        send_footprint(footprint(FP_BOX, 1'b1, -100000, -100000, -50000, -50000));
        send_footprint(footprint(FP_BOX, 1'b1, 100000, 100000, 8388607, 8388607));
        send_footprint(footprint(FP_BOX, 1'b1, -5121, 10239, 5119, 10240));
        wait_drained();
    endtask

    task automatic test_grid_extremes();
        write_reg(CFG_ORIGIN_X, 24'h7FFFFF);
        write_reg(CFG_ORIGIN_Z, 24'h800000);
        write_reg(CFG_WIDTH_X, 24'h000000);
        write_reg(CFG_WIDTH_Z, 24'h800000);
        write_reg(CFG_CELLS_X, 24'hFFFFF0);
        write_reg(CFG_CELLS_Z, 24'h00000F);
        send_footprint(footprint(FP_BOX, 1'b1, 8388600, -8388608, 8388607, -8388601));
        send_footprint(footprint(FP_SEGMENT, 1'b1, -8388608, -8388604, 8388607, -8388606));
        wait_drained();
        write_reg(CFG_ORIGIN_X, 24'h800000);
        write_reg(CFG_ORIGIN_Z, 24'h7FFFFF);
        write_reg(CFG_WIDTH_X, 24'hFFFFFF);
        write_reg(CFG_WIDTH_Z, 24'h7FFFFF);
        write_reg(CFG_CELLS_X, 24'h000009);
        write_reg(CFG_CELLS_Z, 24'h000001);
        send_footprint(footprint(FP_BOX, 1'b1, -8388608, -8388608, 8388607, 8388607));
        wait_drained();
        // writes past the register list must leave the grid alone
        write_reg(CFG_SPARE_LO, CFG_DAT_W'($urandom));
        write_reg(CFG_SPARE_HI, CFG_DAT_W'($urandom));
        send_footprint(footprint(FP_BOX, 1'b1, -8388608, -8388608, 8388607, 8388607));
        send_footprint(footprint(FP_SEGMENT, 1'b1, 8388607, 0, -8388608, 0));
        wait_drained();
    endtask

    task automatic test_random_grids(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            random_grid();
            for (int i = 0; i < per_phase; i++) begin
                send_footprint(random_footprint());
            end
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        random_grid();
        for (int i = 0; i < 25; i++) begin
            send_footprint(random_footprint());
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin : check_cells
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (cells_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, got index %0d last %0b",
                         $time, o_result.cell_index, o_result.last_cell);
            end else begin
                want = cells_due.pop_front();
                if (o_result.cell_index !== want.cell_index) begin
                    errors++;
                    $display("%0t: cell_index mismatch: expected %0d, got %0d",
                             $time, want.cell_index, o_result.cell_index);
                end
                if (o_result.last_cell !== want.last_cell) begin
                    errors++;
                    $display("%0t: last_cell mismatch: expected %0b, got %0b",
                             $time, want.last_cell, o_result.last_cell);
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        errors      = 0;
        gaps_on     = 1'b1;
        grid_org_x  = RST_ORIGIN;
        grid_org_z  = RST_ORIGIN;
        grid_wid_x  = RST_WIDTH;
        grid_wid_z  = RST_WIDTH;
        grid_cols   = RST_CELLS;
        grid_rows   = RST_CELLS;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_grid();
        test_grid_extremes();
        test_random_grids(7, 25);
        test_back_to_back();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### grid_cell_binning_of_bounds.f
design/gcb_pkg.sv
design/gcb_front.sv
design/gcb_queue.sv
design/gcb_back.sv
design/grid_cell_binning_of_bounds.sv
design/gcb_checker.sv
tb/sv/testbench.sv
